### hw/rtl/epsi_pkg.sv
// ----------------------------------------------------------------------------
// epsi_pkg: shared types and constants
// Payload structs, fixed-point scaling and sequencer step codes for the edge
// pressure stabilization error indicator.
// ----------------------------------------------------------------------------
package epsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ACC_W     = 66;              // signed product sums
  localparam int NUM_W     = 160;             // T * |a|^2 * |s|
  localparam int DEN_SH    = 2 * FRAC_BITS + 1;
  localparam int DP_SH     = FRAC_BITS + 1;

  // configuration register indexes
  localparam logic [1:0] CFG_PROJ_TIME_SCALE   = 2'd0;
  localparam logic [1:0] CFG_INCLUDE_GRAD_TERM = 2'd1;

  // multiply step codes
  localparam logic [4:0] STEP_ASQ0 = 5'd0;   // a.a, three steps
  localparam logic [4:0] STEP_ADX0 = 5'd3;   // a.dx, three steps
  localparam logic [4:0] STEP_GDX0 = 5'd6;   // g.dx, three steps
  localparam logic [4:0] STEP_P0   = 5'd9;   // T * |a|^2, two steps
  localparam logic [4:0] STEP_N0   = 5'd11;  // P * |s|, six steps
  localparam logic [4:0] STEP_LAST = 5'd16;

  typedef struct packed {
    logic signed [31:0] area_x;
    logic signed [31:0] area_y;
    logic signed [31:0] area_z;
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
    logic signed [31:0] delta_z;
    logic signed [31:0] grad_sum_x;
    logic signed [31:0] grad_sum_y;
    logic signed [31:0] grad_sum_z;
    logic signed [31:0] pressure_left;
    logic signed [31:0] pressure_right;
    logic               last_edge;
  } in_t;

  typedef struct packed {
    logic [31:0] indicator;
    logic        degenerate_edge;
  } out_t;

endpackage

### hw/rtl/epsi_mul.sv
// ----------------------------------------------------------------------------
// epsi_mul: shared signed multiplier
// 33 x 33 signed multiply with a registered product; unsigned limbs enter
// zero extended.
// ----------------------------------------------------------------------------
module epsi_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] prod_o
);

  always_ff @(posedge clk_i) begin
    prod_o <= a_i * b_i;
  end

endmodule

### hw/rtl/edge_pressure_stab_error_indicator.sv
// ----------------------------------------------------------------------------
// edge_pressure_stab_error_indicator: per-element error indicator
// Sequencer around one shared multiplier, a restoring divider and an
// integer square root.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one mesh edge
//   per transaction. Output channel (out_valid_o / out_stall_i / out_data_o)
//   carries one result per element, produced on the edge flagged last_edge.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at the
//   clock edge and are to be issued only while the block is idle.
// Sequence:
//   An edge runs 17 multiplies on the single multiplier, each issuing its
//   operands and then consuming the product, then one range check, 32
//   divide steps and a square/accumulate. The divide is skipped when the
//   edge value saturates; when a.dx is zero the edge goes from the a.dx
//   check straight to the square/accumulate. A last edge adds 32
//   square-root steps plus an output state. in_stall_o stays high for the
//   whole time, so no new edge is taken until the current one is through.
// Reset:
//   Clears the accumulator, the degenerate flag and all control state, and
//   loads the configuration reset values (scale 1.0, gradient term on).
// Output stall:
//   The result waits in the output register; the block keeps accepting
//   edges and only holds at completion of the next element until the
//   pending result is taken.
// ----------------------------------------------------------------------------
module edge_pressure_stab_error_indicator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  epsi_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output epsi_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i
);
  import epsi_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DCHK, ST_DIV, ST_SQ, ST_SQRT, ST_DONE
  } state_e;

  state_e state_q;
  logic   ph_q;              // 0: issue operands, 1: consume product
  logic [4:0] cnt_q;
  in_t    item_q;

  logic [31:0] scale_q;
  logic        grad_en_q;

  logic signed [ACC_W-1:0] asq_q, adot_q, sgd_q;
  logic [95:0]      p_q;
  logic [NUM_W-1:0] num_q, rem_q, dsh_q;
  logic [31:0]      mag_q;
  logic [63:0]      sum_q;
  logic             deg_q;
  logic [63:0]      x_q, res_q, bit_q;
  logic             deg_hold_q;
  logic             out_valid_q;
  out_t             out_q;

  logic signed [32:0] op_a, op_b;
  logic signed [65:0] prod;

  epsi_mul u_mul (
    .clk_i (clk_i),
    .a_i   (op_a),
    .b_i   (op_b),
    .prod_o(prod)
  );

  // magnitudes of a.dx and of the gradient/pressure term
  logic [ACC_W-1:0] adot_neg, sgd_neg;
  logic [63:0]      axm, sm;
  assign adot_neg = -adot_q;
  assign sgd_neg  = -sgd_q;
  assign axm = adot_q[ACC_W-1] ? adot_neg[63:0] : adot_q[63:0];
  assign sm  = sgd_q[ACC_W-1]  ? sgd_neg[63:0]  : sgd_q[63:0];

  // operand select for the shared multiplier
  logic [4:0]   nidx;
  logic [1:0]   li;
  logic         lj;
  logic [1:0]   pj;
  logic [7:0]   nsh;
  logic [31:0]  a_sel, d_sel, g_sel;
  logic [1:0]   k;

  always_comb begin
    nidx = cnt_q - STEP_N0;
    li   = nidx[2:1];
    lj   = nidx[0];
    nsh  = 8'(32 * (32'(li) + 32'(lj)));
    pj   = 2'(cnt_q - STEP_P0);
    if (cnt_q < STEP_ADX0) begin
      k = 2'(cnt_q - STEP_ASQ0);
    end else if (cnt_q < STEP_GDX0) begin
      k = 2'(cnt_q - STEP_ADX0);
    end else begin
      k = 2'(cnt_q - STEP_GDX0);
    end
    case (k)
      2'd0: begin
        a_sel = item_q.area_x; d_sel = item_q.delta_x; g_sel = item_q.grad_sum_x;
      end
      2'd1: begin
        a_sel = item_q.area_y; d_sel = item_q.delta_y; g_sel = item_q.grad_sum_y;
      end
      default: begin
        a_sel = item_q.area_z; d_sel = item_q.delta_z; g_sel = item_q.grad_sum_z;
      end
    endcase
    op_a = '0;
    op_b = '0;
    if (state_q == ST_SQ) begin
      op_a = {1'b0, mag_q};
      op_b = {1'b0, mag_q};
    end else if (cnt_q < STEP_ADX0) begin
      op_a = {a_sel[31], a_sel};
      op_b = {a_sel[31], a_sel};
    end else if (cnt_q < STEP_GDX0) begin
      op_a = {a_sel[31], a_sel};
      op_b = {d_sel[31], d_sel};
    end else if (cnt_q < STEP_P0) begin
      op_a = {g_sel[31], g_sel};
      op_b = {d_sel[31], d_sel};
    end else if (cnt_q < STEP_N0) begin
      op_a = {1'b0, scale_q};
      op_b = {1'b0, (pj == 2'd0) ? asq_q[31:0] : asq_q[63:32]};
    end else begin
      op_a = {1'b0, p_q[32*li +: 32]};
      op_b = {1'b0, lj ? sm[63:32] : sm[31:0]};
    end
  end

  // divider and root datapath
  logic [NUM_W-1:0] den_w;
  logic [64:0]      sum_add;
  logic [63:0]      sum_new;
  logic [63:0]      trial;
  logic signed [32:0]    dp;
  logic signed [ACC_W-1:0] dp_ext;

  assign den_w   = NUM_W'(axm) << DEN_SH;
  assign sum_add = {1'b0, sum_q} + {1'b0, prod[63:0]};
  assign sum_new = sum_add[64] ? '1 : sum_add[63:0];
  assign trial   = res_q + bit_q;
  assign dp      = {in_data_i.pressure_right[31], in_data_i.pressure_right}
                 - {in_data_i.pressure_left[31], in_data_i.pressure_left};
  assign dp_ext  = ACC_W'(dp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= 1'b0;
      cnt_q       <= '0;
      item_q      <= '0;
      scale_q     <= 32'd65536;
      grad_en_q   <= 1'b1;
      asq_q       <= '0;
      adot_q      <= '0;
      sgd_q       <= '0;
      p_q         <= '0;
      num_q       <= '0;
      rem_q       <= '0;
      dsh_q       <= '0;
      mag_q       <= '0;
      sum_q       <= '0;
      deg_q       <= 1'b0;
      x_q         <= '0;
      res_q       <= '0;
      bit_q       <= '0;
      deg_hold_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // drop a taken result; the done state reloads the register itself
      if (out_valid_q && !out_stall_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PROJ_TIME_SCALE:   scale_q   <= cfg_data_i;
          CFG_INCLUDE_GRAD_TERM: grad_en_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_data_i;
            asq_q   <= '0;
            adot_q  <= '0;
            sgd_q   <= -(dp_ext <<< DP_SH);
            p_q     <= '0;
            num_q   <= '0;
            mag_q   <= '0;
            cnt_q   <= STEP_ASQ0;
            ph_q    <= 1'b0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (!ph_q) begin
            // a.dx is final here: drop a degenerate edge
            if (cnt_q == STEP_P0 && adot_q == '0) begin
              deg_q   <= 1'b1;
              mag_q   <= '0;
              state_q <= ST_SQ;
            end else begin
              ph_q <= 1'b1;
            end
          end else begin
            ph_q <= 1'b0;
            if (cnt_q < STEP_ADX0) begin
              asq_q <= asq_q + prod;
            end else if (cnt_q < STEP_GDX0) begin
              adot_q <= adot_q + prod;
            end else if (cnt_q < STEP_P0) begin
              if (grad_en_q) begin
                sgd_q <= sgd_q + prod;
              end
            end else if (cnt_q < STEP_N0) begin
              p_q <= p_q + (96'(prod[63:0]) << (32 * 32'(pj)));
            end else begin
              num_q <= num_q + (NUM_W'(prod[63:0]) << nsh);
            end
            if (cnt_q == STEP_LAST) begin
              state_q <= ST_DCHK;
            end else begin
              cnt_q <= cnt_q + 5'd1;
            end
          end
        end
        ST_DCHK: begin
          rem_q <= num_q;
          dsh_q <= den_w << 31;
          cnt_q <= 5'd31;
          if (num_q >= (den_w << 32)) begin
            mag_q   <= '1;
            ph_q    <= 1'b0;
            state_q <= ST_SQ;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem_q >= dsh_q) begin
            rem_q        <= rem_q - dsh_q;
            mag_q[cnt_q] <= 1'b1;
          end
          dsh_q <= dsh_q >> 1;
          if (cnt_q == 5'd0) begin
            ph_q    <= 1'b0;
            state_q <= ST_SQ;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        ST_SQ: begin
          if (!ph_q) begin
            ph_q <= 1'b1;
          end else begin
            ph_q <= 1'b0;
            if (item_q.last_edge) begin
              x_q        <= sum_new;
              res_q      <= '0;
              bit_q      <= 64'd1 << 62;
              deg_hold_q <= deg_q;
              sum_q      <= '0;
              deg_q      <= 1'b0;
              cnt_q      <= '0;
              state_q    <= ST_SQRT;
            end else begin
              sum_q   <= sum_new;
              state_q <= ST_IDLE;
            end
          end
        end
        ST_SQRT: begin
          if (x_q >= trial) begin
            x_q   <= x_q - trial;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (cnt_q == 5'd31) begin
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        ST_DONE: begin
          // hold until the previous result is taken
          if (!out_valid_q || !out_stall_i) begin
            out_q.indicator       <= res_q[31:0];
            out_q.degenerate_edge <= deg_hold_q;
            out_valid_q           <= 1'b1;
            state_q               <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_MUL))
    else $error("accepted transaction did not start the sequencer");

  a_root_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> (sum_q == '0 && !deg_q))
    else $error("element state not cleared during root");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < (dsh_q << 1)))
    else $error("divider remainder out of range");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && out_stall_i) |=> (state_q == ST_DONE))
    else $error("result overwrote a pending transaction");

endmodule

### verif/tb_edge_pressure_stab_error_indicator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_edge_pressure_stab_error_indicator: self-checking edge indicator bench
// Drives mesh edges through the valid/stall input channel and predicts each
// element's error indicator with an exact wide-integer model of the edge
// value, its square, the saturating sum and its root. The bench compares every output
// transaction in order, over several configurations and idle patterns.
// ----------------------------------------------------------------------------
module tb_edge_pressure_stab_error_indicator;
  import epsi_pkg::*;

  localparam int CLK_HALF  = 6;
  localparam int LIMIT     = 1500000;
  localparam int SETTLE    = 300;     // beyond the worst edge plus root time
  localparam int LONG_HOLD = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  edge_pressure_stab_error_indicator u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Mirror of the block's configuration and element state.
  logic [31:0] time_scale = 32'd65536;
  logic        grad_on = 1'b1;
  logic [63:0] elem_sum_sq = '0;
  logic        elem_degen = 1'b0;

  in_t  edge_q[$];        // edges waiting to be offered
  out_t indicator_q[$];   // indicators expected from the block
  int   send_idle = 0;
  int   recv_idle = 0;
  logic recv_hold = 1'b0;
  int   errors = 0;
  int   cycles = 0;

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Advance the element state by one edge; return 1 with the indicator when
  // the edge closes the element.
  function automatic logic indicator_step(in_t e, output out_t res);
    logic signed [67:0] asq, adx, s, dp;
    logic [191:0] num, den, q;
    logic [63:0]  mag, sq;
    asq = 68'(e.area_x) * 68'(e.area_x) + 68'(e.area_y) * 68'(e.area_y)
        + 68'(e.area_z) * 68'(e.area_z);
    adx = 68'(e.area_x) * 68'(e.delta_x) + 68'(e.area_y) * 68'(e.delta_y)
        + 68'(e.area_z) * 68'(e.delta_z);
    s = '0;
    if (grad_on) begin
      s = 68'(e.grad_sum_x) * 68'(e.delta_x) + 68'(e.grad_sum_y) * 68'(e.delta_y)
        + 68'(e.grad_sum_z) * 68'(e.delta_z);
    end
    // the pressure jump sits one bit higher since G is half the gradient sum
    dp = 68'(e.pressure_right) - 68'(e.pressure_left);
    s = s - (dp <<< DP_SH);
    mag = '0;
    if (adx == 0) begin
      elem_degen = 1'b1;
    end else begin
      if (s < 0) s = -s;
      if (adx < 0) adx = -adx;
      num = 192'(time_scale) * 192'(asq) * 192'(s);
      den = 192'(adx) << DEN_SH;
      q = num / den;
      mag = (q > 192'hFFFF_FFFF) ? 64'hFFFF_FFFF : q[63:0];
    end
    sq = mag * mag;
    elem_sum_sq = (elem_sum_sq > ~sq) ? '1 : elem_sum_sq + sq;
    res = '0;
    if (!e.last_edge) return 1'b0;
    res.indicator = 32'(isqrt(elem_sum_sq));
    res.degenerate_edge = elem_degen;
    elem_sum_sq = '0;
    elem_degen = 1'b0;
    return 1'b1;
  endfunction

  // Driver: hold a stalled transaction, else offer the next edge or idle.
  always @(posedge clk_i) begin
    out_t res;
    logic taken;
    taken = in_valid_i && !in_stall_o;
    if (taken && indicator_step(in_data_i, res)) indicator_q.push_back(res);
    if (in_valid_i && !taken) begin
      in_valid_i <= 1'b1;
    end else if (rst_ni && edge_q.size() > 0 && $urandom_range(99) >= send_idle) begin
      in_valid_i <= 1'b1;
      in_data_i  <= edge_q.pop_front();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Monitor: compare each output transaction with the oldest expectation.
  always @(posedge clk_i) begin
    out_t want;
    if (out_valid_o && !out_stall_i) begin
      if (indicator_q.size() == 0) begin
        $error("unexpected indicator %h", out_data_o.indicator);
        errors++;
      end else begin
        want = indicator_q.pop_front();
        if (out_data_o.indicator !== want.indicator) begin
          $error("indicator expected %h actual %h",
                 want.indicator, out_data_o.indicator);
          errors++;
        end
        if (out_data_o.degenerate_edge !== want.degenerate_edge) begin
          $error("degenerate_edge expected %b actual %b",
                 want.degenerate_edge, out_data_o.degenerate_edge);
          errors++;
        end
      end
    end
    out_stall_i <= recv_hold || ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    logic [31:0] ext[5];
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF};
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(32'h10_0000) - 32'h8_0000;
      2: return $urandom_range(32'h4_0000) - 32'h2_0000;
      default: return ext[$urandom_range(4)];
    endcase
  endfunction

  function automatic in_t make_edge(logic last);
    in_t e;
    e.area_x = pick_value();  e.area_y = pick_value();  e.area_z = pick_value();
    e.delta_x = pick_value(); e.delta_y = pick_value(); e.delta_z = pick_value();
    e.grad_sum_x = pick_value(); e.grad_sum_y = pick_value();
    e.grad_sum_z = pick_value();
    e.pressure_left = pick_value(); e.pressure_right = pick_value();
    if ($urandom_range(9) < 3) begin   // 2D edge
      e.area_z = '0; e.delta_z = '0; e.grad_sum_z = '0;
    end
    if ($urandom_range(9) == 0) begin  // zero a.dx
      e.delta_x = '0; e.delta_y = '0; e.delta_z = '0;
    end
    e.last_edge = last;
    return e;
  endfunction

  // Queue whole elements, with some random last flags as noise.
  task automatic queue_elements(int n_edges);
    int left;
    while (n_edges > 0) begin
      left = $urandom_range(1, 6);
      for (int k = 0; k < left && n_edges > 0; k++, n_edges--) begin
        if ($urandom_range(9) == 0) edge_q.push_back(make_edge(1'($urandom_range(1))));
        else edge_q.push_back(make_edge(k == left - 1 || n_edges == 1));
      end
    end
  endtask

  // Drain: every edge accepted, every indicator seen, block quiet.
  task automatic drain();
    while (edge_q.size() > 0 || in_valid_i || indicator_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Present one write for one clock edge, after which the enable drops.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PROJ_TIME_SCALE) time_scale = val;
    else if (idx == CFG_INCLUDE_GRAD_TERM) grad_on = val[0];
  endtask

  task automatic directed_edges();
    in_t e;
    e = '{default: 32'h7FFF_FFFF, last_edge: 1'b1};
    edge_q.push_back(e);
    e = '{default: 32'h8000_0000, last_edge: 1'b1};
    edge_q.push_back(e);
    e = '{default: 32'h0, last_edge: 1'b1};                 // zero a.dx
    edge_q.push_back(e);
    e = '{default: 32'h0001_0000, last_edge: 1'b0};         // unit edge
    edge_q.push_back(e);
    e.pressure_right = 32'h0003_0000;
    e.last_edge = 1'b1;
    edge_q.push_back(e);
    // tiny a.dx with huge pressure jump: the edge value saturates
    e = '{default: 32'h0, last_edge: 1'b0};
    e.area_x = 32'h7FFF_FFFF; e.delta_x = 32'h1;
    e.pressure_left = 32'h8000_0000; e.pressure_right = 32'h7FFF_FFFF;
    for (int k = 0; k < 5; k++) edge_q.push_back(e);        // accumulator saturates
    e.last_edge = 1'b1;
    edge_q.push_back(e);
    // degenerate edge followed by a normal one in the same element
    e = '{default: 32'h0002_0000, last_edge: 1'b0};
    e.delta_x = 32'hFFFE_0000; e.delta_y = 32'h0002_0000; e.delta_z = 32'h0;
    edge_q.push_back(e);
    e = '{default: 32'h0001_8000, last_edge: 1'b1};
    e.pressure_left = 32'hFFFF_0000;
    edge_q.push_back(e);
    for (int k = 0; k < 6; k++) edge_q.push_back(make_edge(1'(k % 2)));
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_edges();
    drain();

    // gradient term off, scale at its top, sender idling
    write_reg(CFG_PROJ_TIME_SCALE, 32'hFFFF_FFFF);
    write_reg(CFG_INCLUDE_GRAD_TERM, 32'h0);
    send_idle = 59;
    queue_elements(200);
    drain();

    // zero scale, receiver stalling; out-of-range indexes are ignored
    write_reg(CFG_PROJ_TIME_SCALE, 32'h0);
    write_reg(2'd2, $urandom);
    write_reg(2'd3, $urandom);
    write_reg(CFG_INCLUDE_GRAD_TERM, 32'h1);
    send_idle = 0;
    recv_idle = 59;
    queue_elements(200);
    drain();

    // random scale, both sides idling
    write_reg(CFG_PROJ_TIME_SCALE, $urandom);
    send_idle = 31;
    recv_idle = 31;
    queue_elements(200);
    drain();

    // long receiver hold while the sender keeps offering edges
    write_reg(CFG_PROJ_TIME_SCALE, 32'd65536);
    send_idle = 0;
    recv_idle = 0;
    queue_elements(120);
    recv_hold = 1'b1;
    for (int c = 0; c < LONG_HOLD; c++) @(posedge clk_i);
    recv_hold = 1'b0;
    drain();

    // no idling, small scale, then a random one
    write_reg(CFG_PROJ_TIME_SCALE, 32'h0000_0100);
    queue_elements(150);
    drain();
    write_reg(CFG_PROJ_TIME_SCALE, $urandom);
    write_reg(CFG_INCLUDE_GRAD_TERM, 32'h0);
    send_idle = 31;
    recv_idle = 31;
    queue_elements(110);
    drain();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
